FILE: rtl/lcdfmt_pkg.sv
// Shared types, character codes and controller/datapath interface structs.
`timescale 1ns / 1ps

package lcdfmt_pkg;

  // Request kinds.
  localparam logic [2:0] KIND_CHAR = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_SDEC = 3'd2;
  localparam logic [2:0] KIND_HEX  = 3'd3;
  localparam logic [2:0] KIND_BIN  = 3'd4;

  // Display rows that get a set-address command.
  localparam logic [1:0] LINE_ONE = 2'd1;
  localparam logic [1:0] LINE_TWO = 2'd2;

  // Bus codes.
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;

  // Digit count limits per kind.
  localparam logic [4:0] MAX_DEC_DIGITS = 5'd5;
  localparam logic [4:0] MAX_HEX_DIGITS = 5'd4;
  localparam logic [4:0] MAX_BIN_DIGITS = 5'd16;

  // Binary to BCD conversion: a 17-bit magnitude into five BCD digits.
  localparam int MAG_W      = 17;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CONV_STEPS = MAG_W;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [15:0] value;
    logic [4:0]  digit_count;
  } req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } res_t;

  // Which byte the datapath puts on the bus.
  typedef enum logic [1:0] {
    WR_ADDR  = 2'd0,
    WR_SIGN  = 2'd1,
    WR_CHAR  = 2'd2,
    WR_DIGIT = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    logic    conv_step;
    logic    emit;
    wr_sel_t sel;
    logic    last;
    logic    pos_dec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kind_bad;
    logic kind_char;
    logic kind_signed;
    logic kind_decimal;
    logic line_ok;
    logic conv_done;
    logic pos_zero;
    logic pos_one;
  } dp_status_t;

endpackage

FILE: rtl/lcdfmt_ctrl.sv
// Controller state machine: sequences conversion and the bus writes of a request.
`timescale 1ns / 1ps

module lcdfmt_ctrl
  import lcdfmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_CHAR  = 6'b010000,
    S_DIGIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_addr;
  logic   data_follows;

  assign busy = (state != S_IDLE);

  // Character and signed requests always write something after the address.
  assign data_follows = status.kind_char || status.kind_signed || !status.pos_zero;

  always_comb begin
    if (status.kind_char) begin
      after_addr = S_CHAR;
    end else if (status.kind_signed) begin
      after_addr = S_SIGN;
    end else if (!status.pos_zero) begin
      after_addr = S_DIGIT;
    end else begin
      after_addr = S_IDLE;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.sel       = WR_ADDR;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (status.kind_bad) begin
          state_next = S_IDLE;
        end else if (status.kind_decimal && !status.conv_done) begin
          cmd.conv_step = 1'b1;
        end else if (status.line_ok) begin
          state_next = S_ADDR;
        end else begin
          state_next = after_addr;
        end
      end
      S_ADDR: begin
        cmd.emit   = 1'b1;
        cmd.sel    = WR_ADDR;
        cmd.last   = !data_follows;
        state_next = after_addr;
      end
      S_SIGN: begin
        cmd.emit   = 1'b1;
        cmd.sel    = WR_SIGN;
        cmd.last   = status.pos_zero;
        state_next = status.pos_zero ? S_IDLE : S_DIGIT;
      end
      S_CHAR: begin
        cmd.emit   = 1'b1;
        cmd.sel    = WR_CHAR;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_DIGIT: begin
        cmd.emit    = 1'b1;
        cmd.sel     = WR_DIGIT;
        cmd.last    = status.pos_one;
        cmd.pos_dec = 1'b1;
        state_next  = status.pos_one ? S_IDLE : S_DIGIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/lcdfmt_datapath.sv
// Datapath: request registers, binary-to-BCD converter, byte select and output register.
`timescale 1ns / 1ps

module lcdfmt_datapath
  import lcdfmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       strobe,
  output res_t       result
);

  logic [2:0]       kind_r;
  logic [1:0]       line_r;
  logic [4:0]       column_r;
  logic [15:0]      value_r;
  logic             neg_r;
  logic [4:0]       pos;
  logic [MAG_W-1:0] mag;
  logic [BCD_W-1:0] bcd;
  logic [4:0]       conv_cnt;

  logic [4:0]       max_digits;
  logic [4:0]       sat_count;
  logic             req_neg;
  logic [BCD_W-1:0] bcd_adj;
  logic [4:0]       idx;
  logic [3:0]       digit;
  logic [7:0]       digit_char;
  logic [7:0]       addr_sum;
  res_t             wr;

  // Digit count saturation by kind.
  always_comb begin
    if (req.kind == KIND_HEX) begin
      max_digits = MAX_HEX_DIGITS;
    end else if (req.kind == KIND_BIN) begin
      max_digits = MAX_BIN_DIGITS;
    end else begin
      max_digits = MAX_DEC_DIGITS;
    end
    sat_count = (req.digit_count > max_digits) ? max_digits : req.digit_count;
  end

  assign req_neg = (req.kind == KIND_SDEC) && req.value[15];

  // Double dabble: bias every BCD digit of five or more by three before the shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= req.kind;
      line_r   <= req.line;
      column_r <= req.column;
      value_r  <= req.value;
      neg_r    <= req_neg;
      pos      <= sat_count;
      mag      <= req_neg ? (MAG_W'(17'h10000) - {1'b0, req.value}) : {1'b0, req.value};
      bcd      <= '0;
      conv_cnt <= '0;
    end else begin
      if (cmd.conv_step) begin
        bcd      <= {bcd_adj[BCD_W-2:0], mag[MAG_W-1]};
        mag      <= {mag[MAG_W-2:0], 1'b0};
        conv_cnt <= conv_cnt + 5'd1;
      end
      if (cmd.pos_dec) begin
        pos <= pos - 5'd1;
      end
    end
  end

  assign status.kind_bad     = (kind_r > KIND_BIN);
  assign status.kind_char    = (kind_r == KIND_CHAR);
  assign status.kind_signed  = (kind_r == KIND_SDEC);
  assign status.kind_decimal = (kind_r == KIND_UDEC) || (kind_r == KIND_SDEC);
  assign status.line_ok      = (line_r == LINE_ONE) || (line_r == LINE_TWO);
  assign status.conv_done    = (conv_cnt == 5'(CONV_STEPS));
  assign status.pos_zero     = (pos == 5'd0);
  assign status.pos_one      = (pos == 5'd1);

  // The digit written is the one at position pos-1, most significant first.
  assign idx = pos - 5'd1;

  always_comb begin
    if (kind_r == KIND_HEX) begin
      digit = 4'(value_r >> {idx[1:0], 2'b00});
    end else if (kind_r == KIND_BIN) begin
      digit = {3'b000, value_r[idx[3:0]]};
    end else begin
      digit = 4'(bcd >> {idx[2:0], 2'b00});
    end
    if (digit < 4'd10) begin
      digit_char = CHAR_ZERO + {4'b0000, digit};
    end else begin
      digit_char = CHAR_UPPER_A + {4'b0000, digit} - 8'd10;
    end
  end

  // Column is counted from one; the sum wraps to eight bits.
  assign addr_sum = {3'b000, column_r} + 8'hFF + ((line_r == LINE_TWO) ? LINE2_OFFSET : 8'h00);

  always_comb begin
    wr.last = cmd.last;
    case (cmd.sel)
      WR_ADDR: begin
        wr.is_data  = 1'b0;
        wr.bus_byte = CMD_SET_ADDR | addr_sum;
      end
      WR_SIGN: begin
        wr.is_data  = 1'b1;
        wr.bus_byte = neg_r ? CHAR_MINUS : CHAR_PLUS;
      end
      WR_CHAR: begin
        wr.is_data  = 1'b1;
        wr.bus_byte = value_r[7:0];
      end
      WR_DIGIT: begin
        wr.is_data  = 1'b1;
        wr.bus_byte = digit_char;
      end
      default: begin
        wr.is_data  = 1'b1;
        wr.bus_byte = digit_char;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= wr;
    end
  end

endmodule

FILE: rtl/lcd_number_text_formatter_top.sv
// Top level of the character-LCD number formatter.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. It first passes through
// the converter state, where decimal kinds also run the bit-serial binary-to-BCD
// conversion. The bus writes then follow one per clock with no gaps: an optional
// set-address command, then either the character for a character request or a
// sign for signed decimal and the digits, the last write flagged by last. Each
// write is held on result for exactly one cycle with strobe high and cannot be
// stalled, so the receiver must take it then. Kinds 5 to 7 produce no writes.
module lcd_number_text_formatter_top
  import lcdfmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic strobe,
  output res_t result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lcdfmt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  lcdfmt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

endmodule

FILE: rtl/lcdfmt_checker.sv
// Port-level checker for the formatter and its bind to the top level.
`timescale 1ns / 1ps

module lcdfmt_checker
  import lcdfmt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic strobe,
  input res_t result
);

  // A transaction always occupies the block for at least the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  // Command writes are only ever set-address commands.
  a_cmd_is_addr: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.is_data) |-> result.bus_byte[7])
    else $error("command write without the set-address bit");

  // The writes of one request come in consecutive cycles.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe)
    else $error("gap inside the writes of a request");

  // A set-address command is never directly followed by another one.
  a_no_double_cmd: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.is_data) |=> !(strobe && !result.is_data))
    else $error("two command writes in a row");

  // A reserved kind is dropped straight from the converter state without any write.
  a_bad_kind_dropped: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.kind > KIND_BIN)) |=> (busy && !strobe) ##1 (!busy && !strobe))
    else $error("reserved kind was not dropped silently");

endmodule

bind lcd_number_text_formatter_top lcdfmt_checker u_lcdfmt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .strobe (strobe),
  .result (result)
);

FILE: bench/lcd_write_checker.sv
// Checker that predicts and compares the LCD bus writes caused by each request.
`timescale 1ns / 1ps

module lcd_write_checker
  import lcdfmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic strobe,
  input  res_t result,
  output int   error_count,
  output int   pending_count,
  output int   request_count,
  output int   write_count
);

  localparam int MAX_WRITES = 18;
  localparam int REPORT_LIMIT = 10;

  res_t expected_writes[$];
  int   mismatch_total = 0;
  int   accepted_total = 0;
  int   strobe_total = 0;
  int   queued_total = 0;

  assign error_count   = mismatch_total;
  assign pending_count = queued_total;
  assign request_count = accepted_total;
  assign write_count   = strobe_total;

  function automatic res_t make_write(logic is_data, logic [7:0] bus_byte);
    res_t w;
    w.is_data  = is_data;
    w.bus_byte = bus_byte;
    w.last     = 1'b0;
    return w;
  endfunction

  // Works out the bus writes one request causes and queues them in order.
  function automatic void predict_bus_writes(req_t r);
    res_t        batch [MAX_WRITES];
    int          n;
    int          ndig;
    int unsigned mag;
    int unsigned divisor;
    int unsigned digit;
    logic [4:0]  maxd;
    logic [7:0]  addr;
    logic [7:0]  ch;
    n = 0;
    if (r.kind > KIND_BIN) begin
      return;
    end
    if (r.line == LINE_ONE || r.line == LINE_TWO) begin
      addr = {3'b000, r.column} + 8'hFF + ((r.line == LINE_TWO) ? LINE2_OFFSET : 8'h00);
      batch[n] = make_write(1'b0, CMD_SET_ADDR | addr);
      n++;
    end
    if (r.kind == KIND_CHAR) begin
      batch[n] = make_write(1'b1, r.value[7:0]);
      n++;
    end else begin
      case (r.kind)
        KIND_HEX: maxd = MAX_HEX_DIGITS;
        KIND_BIN: maxd = MAX_BIN_DIGITS;
        default:  maxd = MAX_DEC_DIGITS;
      endcase
      ndig = int'((r.digit_count > maxd) ? maxd : r.digit_count);
      mag = 32'(r.value);
      if (r.kind == KIND_SDEC) begin
        if (r.value[15]) begin
          batch[n] = make_write(1'b1, CHAR_MINUS);
          mag = 32'h10000 - 32'(r.value);
        end else begin
          batch[n] = make_write(1'b1, CHAR_PLUS);
        end
        n++;
      end
      for (int pos = ndig - 1; pos >= 0; pos--) begin
        if (r.kind == KIND_HEX) begin
          digit = (mag >> (4 * pos)) & 4'hF;
          ch = (digit < 10) ? CHAR_ZERO + 8'(digit) : CHAR_UPPER_A + 8'(digit - 10);
        end else if (r.kind == KIND_BIN) begin
          ch = CHAR_ZERO + 8'((mag >> pos) & 1);
        end else begin
          divisor = 1;
          for (int i = 0; i < pos; i++) begin
            divisor = divisor * 10;
          end
          ch = CHAR_ZERO + 8'((mag / divisor) % 10);
        end
        batch[n] = make_write(1'b1, ch);
        n++;
      end
    end
    if (n > 0) begin
      batch[n - 1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_writes.push_back(batch[i]);
    end
  endfunction

  // Results are compared before a new request is predicted, so a transaction
  // and a write on the same edge never get mixed up.
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (strobe) begin
        strobe_total++;
        if (expected_writes.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_LIMIT) begin
            $display("%0t: unexpected write: is_data=%0b byte=%02h last=%0b", $realtime,
                     result.is_data, result.bus_byte, result.last);
          end
        end else begin
          want = expected_writes.pop_front();
          if (result.is_data !== want.is_data || result.bus_byte !== want.bus_byte ||
              result.last !== want.last) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT) begin
              $write("%0t: write mismatch: expected is_data=%0b byte=%02h last=%0b,",
                     $realtime, want.is_data, want.bus_byte, want.last);
              $display(" got is_data=%0b byte=%02h last=%0b",
                       result.is_data, result.bus_byte, result.last);
            end
          end
        end
      end
      if (start && !busy) begin
        accepted_total++;
        predict_bus_writes(req);
      end
    end
    queued_total = expected_writes.size();
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top: drives display requests into the formatter and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
  import lcdfmt_pkg::*;

  localparam logic [2:0] KIND_RSVD_5 = 3'd5;
  localparam logic [2:0] KIND_RSVD_6 = 3'd6;
  localparam logic [2:0] KIND_RSVD_7 = 3'd7;
  localparam logic [1:0] LINE_NONE_0 = 2'd0;
  localparam logic [1:0] LINE_NONE_3 = 2'd3;
  localparam int RANDOM_ITEMS   = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic strobe;
  res_t result;
  int   error_count;
  int   pending_count;
  int   request_count;
  int   write_count;
  int   idle_cycles;

  lcd_number_text_formatter_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .strobe (strobe),
    .result (result)
  );

  lcd_write_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .strobe        (strobe),
    .result        (result),
    .error_count   (error_count),
    .pending_count (pending_count),
    .request_count (request_count),
    .write_count   (write_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Any accepted transaction or bus write counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d writes still expected.", pending_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic req_t make_req(logic [2:0] kind, logic [1:0] line, logic [4:0] column,
                                    logic [15:0] value, logic [4:0] digit_count);
    req_t r;
    r.kind        = kind;
    r.line        = line;
    r.column      = column;
    r.value       = value;
    r.digit_count = digit_count;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(req_t r, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic random_request(output req_t r);
    logic [2:0]  kind;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [15:0] value;
    logic [4:0]  digit_count;
    if ($urandom_range(0, 9) == 0) begin
      kind = 3'($urandom_range(KIND_RSVD_5, KIND_RSVD_7));
    end else begin
      kind = 3'($urandom_range(KIND_CHAR, KIND_BIN));
    end
    if ($urandom_range(0, 4) == 0) begin
      line = 2'($urandom_range(0, 3));
    end else begin
      line = 2'($urandom_range(LINE_ONE, LINE_TWO));
    end
    if ($urandom_range(0, 6) == 0) begin
      column = 5'($urandom_range(0, 31));
    end else begin
      column = 5'($urandom_range(1, 16));
    end
    case ($urandom_range(0, 3))
      0: value = 16'($urandom_range(0, 15));
      1: begin
        case ($urandom_range(0, 3))
          0: value = 16'h0000;
          1: value = 16'hFFFF;
          2: value = 16'h8000;
          default: value = 16'h7FFF;
        endcase
      end
      default: value = 16'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      digit_count = 5'($urandom_range(0, 31));
    end else begin
      digit_count = 5'($urandom_range(0, 16));
    end
    r = make_req(kind, line, column, value, digit_count);
  endtask

  initial begin
    req_t directed [$];
    req_t r;
    int   gap;
    bit   burst;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed.push_back(make_req(KIND_CHAR, LINE_ONE, 5'd1, 16'h0041, 5'd0));
    directed.push_back(make_req(KIND_CHAR, LINE_TWO, 5'd16, 16'hFFFF, 5'd31));
    directed.push_back(make_req(KIND_CHAR, LINE_NONE_0, 5'd0, 16'h007F, 5'd9));
    directed.push_back(make_req(KIND_UDEC, LINE_ONE, 5'd1, 16'h0000, 5'd5));
    directed.push_back(make_req(KIND_UDEC, LINE_TWO, 5'd16, 16'hFFFF, 5'd31));
    directed.push_back(make_req(KIND_UDEC, LINE_NONE_0, 5'd5, 16'd12345, 5'd3));
    directed.push_back(make_req(KIND_UDEC, LINE_ONE, 5'd1, 16'h0000, 5'd0));
    // Column zero wraps to address 0xFF; most negative value has magnitude 32768.
    directed.push_back(make_req(KIND_SDEC, LINE_ONE, 5'd0, 16'h8000, 5'd5));
    directed.push_back(make_req(KIND_SDEC, LINE_TWO, 5'd31, 16'h7FFF, 5'd16));
    directed.push_back(make_req(KIND_SDEC, LINE_NONE_3, 5'd2, 16'hFFFF, 5'd0));
    directed.push_back(make_req(KIND_SDEC, LINE_ONE, 5'd3, 16'h0000, 5'd2));
    directed.push_back(make_req(KIND_HEX, LINE_ONE, 5'd4, 16'hABCD, 5'd4));
    directed.push_back(make_req(KIND_HEX, LINE_TWO, 5'd17, 16'h09AF, 5'd31));
    // No address command and no digits: this request causes no write at all.
    directed.push_back(make_req(KIND_HEX, LINE_NONE_0, 5'd1, 16'hFFFF, 5'd0));
    directed.push_back(make_req(KIND_BIN, LINE_ONE, 5'd8, 16'hA5C3, 5'd16));
    directed.push_back(make_req(KIND_BIN, LINE_TWO, 5'd1, 16'hFFFF, 5'd31));
    directed.push_back(make_req(KIND_BIN, LINE_NONE_3, 5'd1, 16'h0001, 5'd1));
    directed.push_back(make_req(KIND_RSVD_5, LINE_ONE, 5'd1, 16'h1234, 5'd5));
    directed.push_back(make_req(KIND_RSVD_6, LINE_TWO, 5'd16, 16'h0000, 5'd0));
    directed.push_back(make_req(KIND_RSVD_7, LINE_NONE_3, 5'd31, 16'hFFFF, 5'd31));
    directed.push_back(make_req(KIND_UDEC, LINE_TWO, 5'd9, 16'd65535, 5'd2));

    foreach (directed[i]) begin
      send_request(directed[i], $urandom_range(0, 12));
    end

    burst = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Switch between back-to-back stretches and randomly spaced requests.
      if (i % 16 == 0) begin
        burst = ($urandom_range(0, 9) < 3);
      end
      gap = burst ? 0 : $urandom_range(0, 12);
      random_request(r);
      send_request(r, gap);
    end
    start <= 1'b0;

    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests over all kinds, rows and digit counts; checked %0d bus writes.",
             request_count, write_count);
    $display("Mismatches: %0d, writes still expected: %0d.", error_count, pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: lcd_number_text_formatter_top.f
rtl/lcdfmt_pkg.sv
rtl/lcdfmt_ctrl.sv
rtl/lcdfmt_datapath.sv
rtl/lcd_number_text_formatter_top.sv
rtl/lcdfmt_checker.sv
bench/lcd_write_checker.sv
bench/tb_top.sv
